### sv/fes_pkg.sv
package fes_pkg;

   localparam int MAX_FILES_DEF       = 64;
   localparam int MAP_SLOTS_DEF       = 1023;
   localparam int BLOCK_BITS_DEF      = 12;
   localparam int MAX_DATA_BLOCKS_DEF = 65536;

   localparam int RESULT_LIMIT = 64;
   localparam int NRES_W       = $clog2(RESULT_LIMIT + 1);

   localparam int OP_W       = 2;
   localparam int FILE_W     = 6;
   localparam int SLOT_W     = 10;
   localparam int VALUE_W    = 32;
   localparam int OFFSET_W   = 32;
   localparam int LENGTH_W   = 18;
   localparam int DBLK_W     = 16;
   localparam int START_W    = 12;
   localparam int SEG_W      = 13;
   localparam int SOFAR_W    = 18;
   localparam int STATUS_W   = 2;
   localparam int FCOUNT_W   = 7;
   localparam int DBCOUNT_W  = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   typedef enum logic [OP_W-1:0] {
      OP_READ        = 2'd0,
      OP_LOAD_LENGTH = 2'd1,
      OP_LOAD_MAP    = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_FILE  = 2'd1,
      ST_PAST_MAP  = 2'd2,
      ST_BAD_BLOCK = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILE_COUNT       = 1'd0,
      CSR_DATA_BLOCK_COUNT = 1'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_BAD_FILE,
      RES_EMPTY,
      RES_PAST_MAP,
      RES_SEGMENT
   } res_kind_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [FILE_W-1:0]   file_number;
      logic [SLOT_W-1:0]   map_slot;
      logic [VALUE_W-1:0]  load_value;
      logic [OFFSET_W-1:0] byte_offset;
      logic [LENGTH_W-1:0] byte_length;
   } req_item_type;

   typedef struct packed {
      logic [DBLK_W-1:0]  data_block;
      logic [START_W-1:0] block_start;
      logic [SEG_W-1:0]   segment_bytes;
      logic [SOFAR_W-1:0] bytes_so_far;
      logic               last_segment;
      status_type         status;
   } rsp_item_type;

   typedef struct packed {
      logic         capture;
      logic         wr_length;
      logic         wr_map;
      logic         rd_length;
      logic         check;
      logic         prep;
      logic         push;
      res_kind_type res_kind;
   } fes_cmd_type;

   typedef struct packed {
      op_type op;
      logic   bad_file;
      logic   go;
      logic   past_map;
      logic   out_free;
      logic   res_last;
   } fes_stat_type;

endpackage

### sv/fes_if.sv
interface fes_req_if import fes_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [FILE_W-1:0]   file_number;
   logic [SLOT_W-1:0]   map_slot;
   logic [VALUE_W-1:0]  load_value;
   logic [OFFSET_W-1:0] byte_offset;
   logic [LENGTH_W-1:0] byte_length;

   modport source (
      output valid, operation, file_number, map_slot, load_value, byte_offset, byte_length,
      input  ready
   );
   modport sink (
      input  valid, operation, file_number, map_slot, load_value, byte_offset, byte_length,
      output ready
   );
endinterface

interface fes_rsp_if import fes_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DBLK_W-1:0]   data_block;
   logic [START_W-1:0]  block_start;
   logic [SEG_W-1:0]    segment_bytes;
   logic [SOFAR_W-1:0]  bytes_so_far;
   logic                last_segment;
   logic [STATUS_W-1:0] status;

   modport source (
      output valid, data_block, block_start, segment_bytes, bytes_so_far, last_segment, status,
      input  ready
   );
   modport sink (
      input  valid, data_block, block_start, segment_bytes, bytes_so_far, last_segment, status,
      output ready
   );
endinterface

### sv/file_extent_segmenter.sv
// Channel  Dir  Handshake     Payload
// req_ch   in   valid/ready   operation file_number map_slot load_value byte_offset byte_length
// rsp_ch   out  valid/ready   data_block block_start segment_bytes bytes_so_far last_segment status
// csr      in   csr_write     csr_index csr_data
//
// Load or unused request: accept, then decode (with the table write for a load). Read:
// accept, decode, then per segment the steps limit check, block map read, segment
// compute and push. A bad file answer goes from decode straight to push; an empty read
// or a past-map answer takes limit check and push in place of the segment steps.
// Reset clears the controller, the config registers and the output valid; tables hold
// garbage until loaded. req_ch.ready is high only between requests; a stalled rsp_ch
// holds the request in its push step.
module file_extent_segmenter import fes_pkg::*; #(
   parameter int MAX_FILES       = MAX_FILES_DEF,
   parameter int MAP_SLOTS       = MAP_SLOTS_DEF,
   parameter int BLOCK_BITS      = BLOCK_BITS_DEF,
   parameter int MAX_DATA_BLOCKS = MAX_DATA_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   fes_req_if.sink               req_ch,
   fes_rsp_if.source             rsp_ch,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   req_item_type req_item;
   rsp_item_type rsp_item;
   fes_cmd_type  cmd;
   fes_stat_type stat;
   logic         ready;
   logic         rsp_valid;

   assign req_item.operation   = req_ch.operation;
   assign req_item.file_number = req_ch.file_number;
   assign req_item.map_slot    = req_ch.map_slot;
   assign req_item.load_value  = req_ch.load_value;
   assign req_item.byte_offset = req_ch.byte_offset;
   assign req_item.byte_length = req_ch.byte_length;
   assign req_ch.ready         = ready;

   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.data_block    = rsp_item.data_block;
   assign rsp_ch.block_start   = rsp_item.block_start;
   assign rsp_ch.segment_bytes = rsp_item.segment_bytes;
   assign rsp_ch.bytes_so_far  = rsp_item.bytes_so_far;
   assign rsp_ch.last_segment  = rsp_item.last_segment;
   assign rsp_ch.status        = rsp_item.status;

   fes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fes_dp #(
      .MAX_FILES       (MAX_FILES),
      .MAP_SLOTS       (MAP_SLOTS),
      .BLOCK_BITS      (BLOCK_BITS),
      .MAX_DATA_BLOCKS (MAX_DATA_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_item  (req_item),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### sv/fes_ctrl.sv
module fes_ctrl import fes_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  fes_stat_type stat,
   output fes_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_MAPRD,
      S_SEG,
      S_PUSH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   assign req_ready = ready_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_LOAD_LENGTH: begin
                  cmd.wr_length = 1'b1;
                  state_in      = S_IDLE;
               end
               OP_LOAD_MAP: begin
                  cmd.wr_map = 1'b1;
                  state_in   = S_IDLE;
               end
               OP_READ: begin
                  if (stat.bad_file) begin
                     cmd.res_kind = RES_BAD_FILE;
                     state_in     = S_PUSH;
                  end else begin
                     cmd.rd_length = 1'b1;
                     state_in      = S_CHECK;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_CHECK: begin
            if (!stat.go) begin
               cmd.res_kind = RES_EMPTY;
               state_in     = S_PUSH;
            end else if (stat.past_map) begin
               cmd.res_kind = RES_PAST_MAP;
               state_in     = S_PUSH;
            end else begin
               cmd.check = 1'b1;
               state_in  = S_MAPRD;
            end
         end
         S_MAPRD: begin
            cmd.prep = 1'b1;
            state_in = S_SEG;
         end
         S_SEG: begin
            cmd.res_kind = RES_SEGMENT;
            state_in     = S_PUSH;
         end
         S_PUSH: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = stat.res_last ? S_IDLE : S_CHECK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == S_IDLE)
      else $error("request taken outside idle");

   a_push_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && !stat.out_free) |=> state_ff == S_PUSH)
      else $error("segment left push step while output busy");

endmodule

### sv/fes_dp.sv
module fes_dp import fes_pkg::*; #(
   parameter int MAX_FILES       = MAX_FILES_DEF,
   parameter int MAP_SLOTS       = MAP_SLOTS_DEF,
   parameter int BLOCK_BITS      = BLOCK_BITS_DEF,
   parameter int MAX_DATA_BLOCKS = MAX_DATA_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  req_item_type          req_item,
   input  fes_cmd_type           cmd,
   output fes_stat_type          stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item
);

   localparam int FIDX_W    = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int MAP_DEPTH = MAX_FILES * MAP_SLOTS;
   localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int BSIZE_W   = BLOCK_BITS + 1;
   localparam logic [BSIZE_W-1:0] BLOCK_SIZE = {1'b1, {BLOCK_BITS{1'b0}}};

   logic [VALUE_W-1:0] length_mem [MAX_FILES];
   logic [DBLK_W-1:0]  map_mem    [MAP_DEPTH];

   logic [FCOUNT_W-1:0]  file_count_ff;
   logic [DBCOUNT_W-1:0] dbc_ff;

   op_type               op_ff;
   logic [FILE_W-1:0]    file_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic [OFFSET_W-1:0]  offset_ff;
   logic [LENGTH_W-1:0]  length_ff;
   logic [ADDR_W-1:0]    base_ff;
   logic [LENGTH_W-1:0]  done_ff;
   logic [NRES_W-1:0]    n_ff;

   logic [VALUE_W-1:0]   length_q;
   logic [DBLK_W-1:0]    map_q;

   logic [ADDR_W-1:0]     addr_ff;
   logic [LENGTH_W-1:0]   req_rem_ff;
   logic [OFFSET_W-1:0]   file_rem_ff;
   logic [BSIZE_W-1:0]    blk_rem_ff;
   logic [BLOCK_BITS-1:0] start_ff;

   logic [LENGTH_W-1:0]  m1_ff;
   logic                 blk_lt_req_ff;
   logic                 frem_lt_req_ff;

   rsp_item_type         res_ff, res_in;
   logic [LENGTH_W-1:0]  count_ff, count_in;
   rsp_item_type         out_ff;
   logic                 out_valid_ff;

   logic [31:0]          file_wide;
   logic [FIDX_W-1:0]    file_idx;
   logic [31:0]          idx_wide;
   logic [ADDR_W-1:0]    base_in;
   logic [LENGTH_W-1:0]  blk_rem_ext;
   logic                 out_free;

   logic                 blk_bad;
   logic                 sel;
   logic [LENGTH_W-1:0]  count_seg;
   logic                 lt_req;
   logic                 more;

   assign file_wide   = 32'(file_ff);
   assign file_idx    = file_wide[FIDX_W-1:0];
   assign idx_wide    = offset_ff >> BLOCK_BITS;
   assign base_in     = ADDR_W'(32'(req_item.file_number) * 32'(MAP_SLOTS));
   assign blk_rem_ext = LENGTH_W'(blk_rem_ff);
   assign out_free    = !out_valid_ff || rsp_ready;

   assign stat.op       = op_ff;
   assign stat.bad_file = (file_wide >= 32'(file_count_ff)) || (file_wide >= 32'(MAX_FILES));
   assign stat.go       = (done_ff < length_ff) && (offset_ff < length_q)
                          && (n_ff < NRES_W'(RESULT_LIMIT));
   assign stat.past_map = idx_wide >= 32'(MAP_SLOTS);
   assign stat.out_free = out_free;
   assign stat.res_last = res_ff.last_segment;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   // file length table
   always_ff @(posedge clock) begin
      if (cmd.wr_length && file_wide < 32'(MAX_FILES)) begin
         length_mem[file_idx] <= value_ff;
      end
      if (cmd.rd_length) begin
         length_q <= length_mem[file_idx];
      end
   end

   // block map table
   always_ff @(posedge clock) begin
      if (cmd.wr_map && file_wide < 32'(MAX_FILES) && 32'(slot_ff) < 32'(MAP_SLOTS)) begin
         map_mem[base_ff + ADDR_W'(slot_ff)] <= value_ff[DBLK_W-1:0];
      end
      if (cmd.prep) begin
         map_q <= map_mem[addr_ff];
      end
   end

   // segment limits
   assign blk_bad   = (32'(map_q) >= 32'(dbc_ff)) || (32'(map_q) >= 32'(MAX_DATA_BLOCKS));
   assign sel       = 32'(m1_ff) < file_rem_ff;
   assign count_seg = sel ? m1_ff : file_rem_ff[LENGTH_W-1:0];
   assign lt_req    = sel ? blk_lt_req_ff : frem_lt_req_ff;
   assign more      = lt_req && sel && (n_ff < NRES_W'(RESULT_LIMIT - 1));

   always_comb begin
      res_in   = res_ff;
      count_in = count_ff;
      case (cmd.res_kind)
         RES_BAD_FILE: begin
            res_in              = '0;
            res_in.last_segment = 1'b1;
            res_in.status       = ST_BAD_FILE;
         end
         RES_EMPTY: begin
            res_in              = '0;
            res_in.last_segment = 1'b1;
            res_in.status       = ST_OK;
         end
         RES_PAST_MAP: begin
            res_in              = '0;
            res_in.bytes_so_far = SOFAR_W'(done_ff);
            res_in.last_segment = 1'b1;
            res_in.status       = ST_PAST_MAP;
         end
         RES_SEGMENT: begin
            if (blk_bad) begin
               res_in              = '0;
               res_in.bytes_so_far = SOFAR_W'(done_ff);
               res_in.last_segment = 1'b1;
               res_in.status       = ST_BAD_BLOCK;
            end else begin
               res_in.data_block    = map_q;
               res_in.block_start   = START_W'(start_ff);
               res_in.segment_bytes = SEG_W'(count_seg);
               res_in.bytes_so_far  = SOFAR_W'(done_ff + count_seg);
               res_in.last_segment  = !more;
               res_in.status        = ST_OK;
               count_in             = count_seg;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= op_type'(req_item.operation);
         file_ff   <= req_item.file_number;
         slot_ff   <= req_item.map_slot;
         value_ff  <= req_item.load_value;
         offset_ff <= req_item.byte_offset;
         length_ff <= req_item.byte_length;
         base_ff   <= base_in;
         done_ff   <= '0;
      end else if (cmd.push) begin
         offset_ff <= offset_ff + OFFSET_W'(count_ff);
         done_ff   <= LENGTH_W'(res_ff.bytes_so_far);
      end
      if (cmd.check) begin
         addr_ff     <= base_ff + ADDR_W'(idx_wide);
         req_rem_ff  <= length_ff - done_ff;
         file_rem_ff <= length_q - offset_ff;
         start_ff    <= offset_ff[BLOCK_BITS-1:0];
         blk_rem_ff  <= BLOCK_SIZE - BSIZE_W'(offset_ff[BLOCK_BITS-1:0]);
      end
      if (cmd.prep) begin
         m1_ff          <= (blk_rem_ext < req_rem_ff) ? blk_rem_ext : req_rem_ff;
         blk_lt_req_ff  <= blk_rem_ext < req_rem_ff;
         frem_lt_req_ff <= file_rem_ff < 32'(req_rem_ff);
      end
      res_ff   <= res_in;
      count_ff <= count_in;
      if (cmd.push) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_count_ff <= '0;
         dbc_ff        <= '0;
         out_valid_ff  <= 1'b0;
         n_ff          <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_FILE_COUNT:       file_count_ff <= csr_data[FCOUNT_W-1:0];
               CSR_DATA_BLOCK_COUNT: dbc_ff        <= csr_data[DBCOUNT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.capture) begin
            n_ff <= '0;
         end else if (cmd.push) begin
            n_ff <= n_ff + NRES_W'(1);
         end
      end
   end

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NRES_W'(RESULT_LIMIT))
      else $error("more segments than the result limit");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != ST_OK) |-> out_ff.last_segment)
      else $error("error result not marked last");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != ST_OK)
      |-> (out_ff.segment_bytes == '0 && out_ff.data_block == '0))
      else $error("error result carries segment data");

endmodule
